// ----- sv/fsp_pkg.sv -----
`timescale 1ns / 1ps

package fsp_pkg;

   typedef enum logic [1:0] {
      OP_ACQUIRE = 2'd0,
      OP_RELEASE = 2'd1,
      OP_SELECT  = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_RMW,
      ST_SCAN,
      ST_DONE
   } state_type;

   localparam logic [1:0]  CSR_SLOT_COUNT = 2'd0;
   localparam logic [1:0]  CSR_REF_DEPTH  = 2'd1;

   localparam logic [31:0] TAG_RESET      = 32'hFFFF_FFFF;
   localparam logic [7:0]  FREE_MAX       = 8'hFF;
   localparam logic [4:0]  SLOT_COUNT_RST = 5'd16;
   localparam logic [4:0]  REF_DEPTH_RST  = 5'd0;

   // one stored entry: free flag above the tag
   localparam int ENTRY_W = 33;

   typedef struct packed {
      op_type      operation;
      logic [31:0] source_tag;
   } req_type;

   typedef struct packed {
      logic [3:0] slot_index;
      logic       found;
   } rsp_type;

   typedef struct packed {
      logic [4:0] slot_count;
      logic [4:0] reference_depth;
   } cfg_type;

endpackage

// ----- sv/frame_slot_pool_manager.sv -----
`timescale 1ns / 1ps

// Frame slot pool manager. Each request carries one operation (acquire,
// release by tag, select by tag, query) and yields exactly one response
// with a slot index and a found flag. Slot tags and free flags live in one
// synchronous RAM of MAX_SLOTS entries; a sequencer scans it one slot per
// cycle with the read of the next slot overlapped with the compare of the
// current one. Query and an empty pool go straight to the response;
// release, select and acquire from the free list scan up to the hit or,
// on a miss, through the slot count; round-robin acquire first reduces
// the next slot by one modulo subtraction per step when it lies beyond a
// reduced slot count, then reads and retags that slot. One request is in
// work at a time; the response register lets the next request in while
// the last response waits. There is no clearing pass: per-slot valid bits
// make untouched slots read as untagged and not free right after reset.
// Configuration writes are always ready and must only be issued while the
// block is idle.
module frame_slot_pool_manager #(
   parameter int MAX_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fsp_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fsp_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [4:0]       csr_data
);

   import fsp_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff, rsp_payload_in;

   logic    busy;
   logic    start;
   logic    res_valid;
   rsp_type res;
   logic    res_take;

   // accept a request only while the sequencer is idle
   assign req_stall = busy;
   assign start     = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   fsp_engine #(
      .MAX_SLOTS(MAX_SLOTS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_payload),
      .cfg      (cfg_ff),
      .busy     (busy),
      .res_valid(res_valid),
      .res      (res),
      .res_take (res_take)
   );

   // register writes: unknown indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SLOT_COUNT: cfg_in.slot_count      = csr_data;
            CSR_REF_DEPTH:  cfg_in.reference_depth = csr_data;
            default:        cfg_in                 = cfg_ff;
         endcase
      end
   end

   // output register: load when empty or when its response is taken
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      if (res_take) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = res;
      end else if (rsp_stall) begin
         rsp_valid_in   = rsp_valid_ff;
      end else begin
         rsp_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{slot_count: SLOT_COUNT_RST, reference_depth: REF_DEPTH_RST};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- sv/fsp_ram.sv -----
`timescale 1ns / 1ps

module fsp_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/fsp_engine.sv -----
`timescale 1ns / 1ps

module fsp_engine #(
   parameter int MAX_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  fsp_pkg::req_type req,
   input  fsp_pkg::cfg_type cfg,
   output logic             busy,
   output logic             res_valid,
   output fsp_pkg::rsp_type res,
   input  logic             res_take
);

   import fsp_pkg::*;

   localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [31:0]       tag_ff, tag_in;
   logic [4:0]        n_ff, n_in;
   logic [4:0]        mod_ff, mod_in;
   logic [SW-1:0]     scan_ff, scan_in;
   logic              cur_vld_ff, cur_vld_in;
   logic [SW-1:0]     cur_ff, cur_in;
   logic              chs_vld_ff, chs_vld_in;
   logic [SW-1:0]     chs_ff, chs_in;
   logic [7:0]        free_ff, free_in;
   logic [MAX_SLOTS-1:0] valid_ff, valid_in;
   rsp_type           res_ff, res_in;

   logic              rd_en;
   logic [SW-1:0]     rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic              wr_en;
   logic [SW-1:0]     wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   logic [4:0]        n_eff;
   logic [4:0]        depth;
   logic [6:0]        q_diff;
   logic [6:0]        q_wrap;
   rsp_type           q_res;
   logic [31:0]       ent_tag;
   logic              ent_free;
   logic              hit;
   logic              last;

   fsp_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_SLOTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // slots never written read as untagged and not free
   assign ent_tag  = valid_ff[scan_ff] ? rd_data[31:0] : TAG_RESET;
   assign ent_free = valid_ff[scan_ff] & rd_data[32];
   assign hit      = (op_ff == OP_ACQUIRE) ? ent_free : (ent_tag == tag_ff);
   assign last     = (5'(scan_ff) == (n_ff - 5'd1));

   assign n_eff = (cfg.slot_count > 5'(MAX_SLOTS)) ? 5'(MAX_SLOTS) : cfg.slot_count;
   assign depth = ((cfg.reference_depth == 5'd0) || (cfg.reference_depth >= n_eff))
                  ? n_eff : cfg.reference_depth;
   assign q_diff = 7'(cur_ff) + 7'd1 - 7'(depth);
   assign q_wrap = q_diff + 7'(n_eff);

   always_comb begin
      q_res = '0;
      priority if (!cur_vld_ff) begin
         q_res = '0;
      end else if (chs_vld_ff) begin
         q_res = '{slot_index: 4'(chs_ff), found: 1'b1};
      end else if (!q_diff[6]) begin
         q_res = '{slot_index: q_diff[3:0], found: 1'b1};
      end else if (!q_wrap[6]) begin
         q_res = '{slot_index: q_wrap[3:0], found: 1'b1};
      end else begin
         q_res = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
      end else begin
         state_ff   <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
         chs_vld_ff <= 1'b0;
         free_ff    <= '0;
         valid_ff   <= '0;
      end else begin
         cur_vld_ff <= cur_vld_in;
         chs_vld_ff <= chs_vld_in;
         free_ff    <= free_in;
         valid_ff   <= valid_in;
      end
      op_ff   <= op_in;
      tag_ff  <= tag_in;
      n_ff    <= n_in;
      mod_ff  <= mod_in;
      scan_ff <= scan_in;
      cur_ff  <= cur_in;
      chs_ff  <= chs_in;
      res_ff  <= res_in;
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      tag_in     = tag_ff;
      n_in       = n_ff;
      mod_in     = mod_ff;
      scan_in    = scan_ff;
      cur_vld_in = cur_vld_ff;
      cur_in     = cur_ff;
      chs_vld_in = chs_vld_ff;
      chs_in     = chs_ff;
      free_in    = free_ff;
      res_in     = res_ff;
      rd_en      = 1'b0;
      rd_addr    = scan_ff;
      wr_en      = 1'b0;
      wr_addr    = scan_ff;
      wr_data    = {ent_free, ent_tag};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in   = req.operation;
               tag_in  = req.source_tag;
               n_in    = n_eff;
               scan_in = '0;
               if (n_eff == 5'd0) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  unique case (req.operation)
                     OP_ACQUIRE: begin
                        if (free_ff == 8'd0) begin
                           mod_in   = cur_vld_ff ? (5'(cur_ff) + 5'd1) : 5'd0;
                           state_in = ST_MOD;
                        end else begin
                           rd_en    = 1'b1;
                           rd_addr  = '0;
                           state_in = ST_SCAN;
                        end
                     end
                     OP_RELEASE, OP_SELECT: begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = ST_SCAN;
                     end
                     OP_QUERY: begin
                        res_in   = q_res;
                        state_in = ST_DONE;
                     end
                     default: begin
                        state_in = ST_IDLE;
                     end
                  endcase
               end
            end
         end
         ST_MOD: begin
            // reduce the next round-robin slot by subtraction
            if (mod_ff >= n_ff) begin
               mod_in = mod_ff - n_ff;
            end else begin
               scan_in    = SW'(mod_ff);
               rd_en      = 1'b1;
               rd_addr    = SW'(mod_ff);
               cur_in     = SW'(mod_ff);
               cur_vld_in = 1'b1;
               state_in   = ST_RMW;
            end
         end
         ST_RMW: begin
            // retag, keep the free flag
            wr_en    = 1'b1;
            wr_data  = {ent_free, tag_ff};
            res_in   = '{slot_index: 4'(scan_ff), found: 1'b1};
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (hit) begin
               res_in   = '{slot_index: 4'(scan_ff), found: 1'b1};
               state_in = ST_DONE;
               unique case (op_ff)
                  OP_ACQUIRE: begin
                     wr_en      = 1'b1;
                     wr_data    = {1'b0, tag_ff};
                     free_in    = free_ff - 8'd1;
                     cur_in     = scan_ff;
                     cur_vld_in = 1'b1;
                  end
                  OP_RELEASE: begin
                     wr_en   = 1'b1;
                     wr_data = {1'b1, ent_tag};
                     if (free_ff != FREE_MAX) begin
                        free_in = free_ff + 8'd1;
                     end
                  end
                  OP_SELECT: begin
                     chs_in     = scan_ff;
                     chs_vld_in = 1'b1;
                  end
                  default: begin
                     res_in = res_ff;
                  end
               endcase
            end else if (last) begin
               res_in   = '0;
               state_in = ST_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = scan_ff + SW'(1);
               scan_in = scan_ff + SW'(1);
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

`ifndef NO_ASSERTIONS
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (5'(scan_ff) < n_ff))
      else $error("scan index beyond slot count");

   a_free_only_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN) |=> $stable(free_ff))
      else $error("free count changed outside a slot scan");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res.found) |-> (res.slot_index == 4'd0))
      else $error("miss carries a nonzero slot index");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_SCAN || state_ff == ST_RMW))
      else $error("slot memory written outside a scan or retag");
`endif

endmodule
